// ===== src/assert_macros.svh =====
// Assertion macros shared by the dimmer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/pcdf_pkg.sv =====
// Shared types and constants of the phase-cut dimmer with fade.
package pcdf_pkg;

    // Item kind codes. The last code is unused and leaves the state as it is.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ZC    = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_FADE_RATE    = 2'd0;
    localparam logic [1:0] REG_DELAY_SLOPE  = 2'd1;
    localparam logic [1:0] REG_DELAY_OFFSET = 2'd2;

    localparam int PADDR_W = 4;

    // Register reset values.
    localparam logic [15:0] FADE_RATE_RST    = 16'd256;
    localparam logic [7:0]  DELAY_SLOPE_RST  = 8'd30;
    localparam logic [15:0] DELAY_OFFSET_RST = 16'd400;

    localparam logic [7:0]  TARGET_RST  = 8'd255;
    localparam int          LEVEL_MAX_DEF = 255;
    localparam int          DELAY_W     = 17;
    localparam logic [16:0] DELAY_LIMIT = 17'h1FFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic       want_on;
        logic [7:0] target_level;
        logic       fade_enable;
    } pcdf_item_t;

    typedef struct packed {
        logic [15:0] fade_rate;
        logic [7:0]  delay_slope;
        logic [15:0] delay_offset;
    } pcdf_cfg_t;

endpackage

// ===== src/pcdf_cfg.sv =====
// APB register file holding the fade rate and firing delay settings.
module pcdf_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcdf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pcdf_pkg::pcdf_cfg_t         cfg
);
    import pcdf_pkg::*;

    logic [15:0] fade_rate_reg;
    logic [7:0]  delay_slope_reg;
    logic [15:0] delay_offset_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_rate_reg    <= FADE_RATE_RST;
            delay_slope_reg  <= DELAY_SLOPE_RST;
            delay_offset_reg <= DELAY_OFFSET_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_FADE_RATE:    fade_rate_reg    <= pwdata[15:0];
                REG_DELAY_SLOPE:  delay_slope_reg  <= pwdata[7:0];
                REG_DELAY_OFFSET: delay_offset_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FADE_RATE:    prdata = {16'd0, fade_rate_reg};
            REG_DELAY_SLOPE:  prdata = {24'd0, delay_slope_reg};
            REG_DELAY_OFFSET: prdata = {16'd0, delay_offset_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.fade_rate    = fade_rate_reg;
    assign cfg.delay_slope  = delay_slope_reg;
    assign cfg.delay_offset = delay_offset_reg;

endmodule

// ===== src/pcdf_core.sv =====
// Dimmer state, input register and result register with the per-word update logic.
`include "assert_macros.svh"

module pcdf_core #(
    parameter int LEVEL_MAX = pcdf_pkg::LEVEL_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcdf_pkg::pcdf_cfg_t  cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  pcdf_pkg::pcdf_item_t item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 gate_drive,
    output logic [7:0]           level_now,
    output logic                 lamp_on
);
    import pcdf_pkg::*;

    localparam int LW = $clog2(LEVEL_MAX + 1);
    localparam int FW = LW + 8;
    localparam int SW = ((FW > 16) ? FW : 16) + 1;
    localparam int PW = 8 + LW;
    localparam int DW = ((PW > 16) ? PW : 16) + 1;
    localparam logic [LW-1:0] LMAX      = LW'(LEVEL_MAX);
    localparam logic [FW-1:0] LEVEL_CAP = {LMAX, 8'h00};

    // Input stage.
    logic       s1_valid_reg;
    pcdf_item_t s1_item_reg;

    // Dimmer state.
    logic [FW-1:0]      level_reg,       level_next;
    logic [7:0]         target_reg,      target_next;
    logic               on_reg,          on_next;
    logic               fade_reg,        fade_next;
    logic               busy_reg,        busy_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic               delay_armed_reg, delay_armed_next;
    logic               gate_reg,        gate_next;

    // Result stage.
    logic       out_valid_reg;
    logic       out_gate_reg;
    logic [7:0] out_level_reg;
    logic       out_on_reg;

    logic advance;

    logic [LW-1:0]      whole;
    logic [LW-1:0]      goal;
    logic [FW-1:0]      cap;
    logic [FW-1:0]      floor_lvl;
    logic [SW-1:0]      floor_plus;
    logic [SW-1:0]      rise_sum;
    logic [FW-1:0]      fade_level;
    logic [LW-1:0]      fade_whole;
    logic               fade_on;
    logic               fade_gate;
    logic [PW-1:0]      delay_prod;
    logic [DW-1:0]      delay_sum;
    logic [DELAY_W-1:0] delay_len;

    assign advance    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    // Goal level: the commanded target, clamped to full scale.
    assign whole = level_reg[FW-1:8];
    assign goal  = (16'(target_reg) > 16'(LEVEL_MAX)) ? LMAX : LW'(target_reg);
    assign cap   = {goal, 8'h00};

    // Fade step: move toward the goal by the fade rate, or jump to it.
    assign floor_lvl  = on_reg ? cap : '0;
    assign floor_plus = SW'(floor_lvl) + SW'(cfg.fade_rate);
    assign rise_sum   = SW'(level_reg) + SW'(cfg.fade_rate);

    always_comb
    begin
        fade_level = level_reg;
        if (fade_reg)
        begin
            if ((whole > goal) || (!on_reg && (whole != '0)))
            begin
                if (SW'(level_reg) >= floor_plus)
                begin
                    fade_level = level_reg - FW'(cfg.fade_rate);
                end
                else
                begin
                    fade_level = floor_lvl;
                end
            end
            else if ((whole < goal) && on_reg && (whole < LMAX))
            begin
                fade_level = (rise_sum > SW'(cap)) ? cap : FW'(rise_sum);
            end
        end
        else
        begin
            fade_level = on_reg ? cap : '0;
        end
    end

    // Fully off drops the lamp flag and the gate; full scale sets both.
    assign fade_whole = fade_level[FW-1:8];

    always_comb
    begin
        fade_on   = on_reg;
        fade_gate = 1'b1;
        if (fade_whole == '0)
        begin
            fade_on   = 1'b0;
            fade_gate = 1'b0;
        end
        else if (fade_whole == LMAX)
        begin
            fade_on = 1'b1;
        end
    end

    // Firing delay, saturated to the counter width.
    assign delay_prod = PW'(cfg.delay_slope) * PW'(LMAX - whole);
    assign delay_sum  = DW'(delay_prod) + DW'(cfg.delay_offset);
    assign delay_len  = (delay_sum > DW'(DELAY_LIMIT)) ? DELAY_LIMIT : DELAY_W'(delay_sum);

    always_comb
    begin
        level_next       = level_reg;
        target_next      = target_reg;
        on_next          = on_reg;
        fade_next        = fade_reg;
        busy_next        = busy_reg;
        delay_count_next = delay_count_reg;
        delay_armed_next = delay_armed_reg;
        gate_next        = gate_reg;

        case (s1_item_reg.kind)
            KIND_TICK:
            begin
                if (delay_armed_reg)
                begin
                    if (delay_count_reg <= DELAY_W'(1))
                    begin
                        level_next       = fade_level;
                        on_next          = fade_on;
                        gate_next        = fade_gate;
                        busy_next        = 1'b0;
                        delay_armed_next = 1'b0;
                        delay_count_next = '0;
                    end
                    else
                    begin
                        delay_count_next = delay_count_reg - DELAY_W'(1);
                    end
                end
            end
            KIND_ZC:
            begin
                if (!busy_reg)
                begin
                    if ((whole != '0) && (whole < LMAX))
                    begin
                        busy_next        = 1'b1;
                        gate_next        = 1'b0;
                        delay_count_next = delay_len;
                        delay_armed_next = 1'b1;
                    end
                    else
                    begin
                        level_next       = fade_level;
                        on_next          = fade_on;
                        gate_next        = fade_gate;
                        busy_next        = 1'b0;
                        delay_armed_next = 1'b0;
                        delay_count_next = '0;
                    end
                end
            end
            KIND_CMD:
            begin
                on_next     = s1_item_reg.want_on;
                target_next = s1_item_reg.target_level;
                fade_next   = s1_item_reg.fade_enable;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            target_reg      <= TARGET_RST;
            on_reg          <= 1'b1;
            fade_reg        <= 1'b0;
            busy_reg        <= 1'b0;
            delay_count_reg <= '0;
            delay_armed_reg <= 1'b0;
            gate_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            level_reg       <= level_next;
            target_reg      <= target_next;
            on_reg          <= on_next;
            fade_reg        <= fade_next;
            busy_reg        <= busy_next;
            delay_count_reg <= delay_count_next;
            delay_armed_reg <= delay_armed_next;
            gate_reg        <= gate_next;
            out_valid_reg   <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_gate_reg  <= gate_next;
            out_level_reg <= 8'(level_next[FW-1:8]);
            out_on_reg    <= on_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign gate_drive   = out_gate_reg;
    assign level_now    = out_level_reg;
    assign lamp_on      = out_on_reg;

    `ASSERT_IMPLIES(a_armed_busy, delay_armed_reg, busy_reg, "delay armed outside a half cycle")
    `ASSERT_IMPLIES(a_armed_gate_low, delay_armed_reg, !gate_reg, "gate high while delay armed")
    `ASSERT_HOLDS(a_level_range, level_reg <= LEVEL_CAP, "level above full scale")

endmodule

// ===== src/phase_cut_dimmer_with_fade_unit.sv =====
// Top level of the leading-edge phase-cut dimmer with fade.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      kind, want_on, target_level, fade_enable
//   result    out        result_valid / result_ready  gate_drive, level_now, lamp_on
//   config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// Each word goes into the input register, then through the update logic into the state
// and the result register. A new word is accepted every cycle unless the input register
// is full behind a stalled result; the input register and the result register
// let one word wait at the output while the next one is taken in.
// A stalled result holds the update of the word behind it, so the state always
// follows the words in order. Reset is asynchronous and active low; it restores
// the register defaults, a dark lamp with the on flag set and full target.
module phase_cut_dimmer_with_fade_unit #(
    parameter int LEVEL_MAX = pcdf_pkg::LEVEL_MAX_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcdf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input words: ticks, zero crossings and commands.
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [1:0]                   kind,
    input  logic                         want_on,
    input  logic [7:0]                   target_level,
    input  logic                         fade_enable,
    // Result words: one for every input word.
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         gate_drive,
    output logic [7:0]                   level_now,
    output logic                         lamp_on
);
    import pcdf_pkg::*;

    pcdf_cfg_t  cfg;
    pcdf_item_t item;

    // Pack the input word fields for the core.
    assign item.kind         = kind;
    assign item.want_on      = want_on;
    assign item.target_level = target_level;
    assign item.fade_enable  = fade_enable;

    // Register file: fade rate, delay slope and delay offset.
    pcdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Core: a zero crossing arms the firing delay, or runs the fade step at once at dark or full scale;
    // delay expiry runs the fade step and raises the gate unless dark; commands update the target and the mode flags.
    pcdf_core #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .gate_drive   (gate_drive),
        .level_now    (level_now),
        .lamp_on      (lamp_on)
    );

endmodule

// ===== test/tb_phase_cut_dimmer_with_fade_unit.sv =====
// Self-checking testbench for the phase-cut dimmer: directed and random words, predicted results.
`timescale 1ns / 1ps

module tb_phase_cut_dimmer_with_fade_unit;
    import pcdf_pkg::*;

    localparam int LEVEL_TOP = LEVEL_MAX_DEF;

    // Predicted state of the dimmer. The level is kept in 8.8 fixed point.
    typedef struct packed {
        logic [15:0] level_fx;
        logic [7:0]  target;
        logic        on_flag;
        logic        fade_flag;
        logic        busy;
        logic        armed;
        logic        gate;
        logic [16:0] count;
    } lamp_state_t;

    // What the block reports after each word.
    typedef struct packed {
        logic       gate;
        logic [7:0] level;
        logic       lit;
    } lamp_out_t;

    logic clk;
    logic rst_n;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic       item_valid   = 1'b0;
    logic       item_ready;
    logic [1:0] kind         = KIND_TICK;
    logic       want_on      = 1'b0;
    logic [7:0] target_level = '0;
    logic       fade_enable  = 1'b0;

    logic       result_valid;
    logic       result_ready = 1'b0;
    logic       gate_drive;
    logic [7:0] level_now;
    logic       lamp_on;

    phase_cut_dimmer_with_fade_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .want_on      (want_on),
        .target_level (target_level),
        .fade_enable  (fade_enable),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .gate_drive   (gate_drive),
        .level_now    (level_now),
        .lamp_on      (lamp_on)
    );

    // Words waiting to be offered, and results still owed by the block.
    pcdf_item_t word_q[$];
    lamp_out_t  lamp_q[$];

    // The current register settings. They change only while the block is idle,
    // so one copy serves both the stimulus planner and the checker.
    pcdf_cfg_t   cfg_now;
    // The planner runs ahead of the block to shape the stimulus; the checker
    // advances only when a word is actually accepted.
    lamp_state_t plan_st;
    lamp_state_t live_st;

    logic item_taken   = 1'b0;
    int   results_seen = 0;
    int   fault_count  = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lamp_state_t reset_state();
        lamp_state_t s;
        s = '0;
        s.target  = TARGET_RST;
        s.on_flag = 1'b1;
        return s;
    endfunction

    // One fade step: either move the level toward its goal by the fade rate,
    // or jump straight to it. Then the gate and the on flag follow the level.
    function automatic lamp_state_t fade_step(lamp_state_t s, pcdf_cfg_t c);
        lamp_state_t n;
        int unsigned lvl;
        int unsigned whole;
        int unsigned goal;
        int unsigned floor_fx;
        int unsigned rate;
        n     = s;
        lvl   = 32'(s.level_fx);
        whole = lvl >> 8;
        goal  = 32'(s.target);
        rate  = 32'(c.fade_rate);
        if (goal > LEVEL_TOP)
            goal = LEVEL_TOP;
        if (s.fade_flag)
        begin
            if (whole > goal || (!s.on_flag && whole > 0))
            begin
                // Falling: the floor is the target while on, dark while off.
                floor_fx = s.on_flag ? (goal << 8) : 0;
                if (lvl >= floor_fx + rate)
                    lvl = lvl - rate;
                else
                    lvl = floor_fx;
            end
            else if (whole < goal && s.on_flag && whole < LEVEL_TOP)
            begin
                lvl = lvl + rate;
                if (lvl > (goal << 8))
                    lvl = goal << 8;
            end
        end
        else
        begin
            lvl = s.on_flag ? (goal << 8) : 0;
        end
        n.level_fx = lvl[15:0];
        whole = lvl >> 8;
        if (whole == 0)
        begin
            n.on_flag = 1'b0;
            n.gate    = 1'b0;
        end
        else if (whole == LEVEL_TOP)
        begin
            n.on_flag = 1'b1;
            n.gate    = 1'b1;
        end
        else
        begin
            n.gate = 1'b1;
        end
        n.busy  = 1'b0;
        n.armed = 1'b0;
        n.count = '0;
        return n;
    endfunction

    function automatic lamp_state_t dimmer_next(lamp_state_t s, pcdf_item_t w, pcdf_cfg_t c);
        lamp_state_t n;
        int unsigned whole;
        int unsigned wait_ticks;
        n = s;
        case (w.kind)
            KIND_TICK:
            begin
                if (s.armed)
                begin
                    if (s.count <= 17'd1)
                        n = fade_step(s, c);
                    else
                        n.count = s.count - 1'b1;
                end
            end
            KIND_ZC:
            begin
                // A crossing that arrives while a firing delay runs is dropped.
                if (!s.busy)
                begin
                    whole  = 32'(s.level_fx[15:8]);
                    n.busy = 1'b1;
                    if (whole > 0 && whole < LEVEL_TOP)
                    begin
                        wait_ticks = 32'(c.delay_slope) * (32'(LEVEL_TOP) - whole)
                                   + 32'(c.delay_offset);
                        if (wait_ticks > 32'(DELAY_LIMIT))
                            wait_ticks = 32'(DELAY_LIMIT);
                        n.gate  = 1'b0;
                        n.count = wait_ticks[16:0];
                        n.armed = 1'b1;
                    end
                    else
                    begin
                        n = fade_step(n, c);
                    end
                end
            end
            KIND_CMD:
            begin
                n.on_flag   = w.want_on;
                n.target    = w.target_level;
                n.fade_flag = w.fade_enable;
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic lamp_out_t lamp_view(lamp_state_t s);
        lamp_out_t o;
        o.gate  = s.gate;
        o.level = s.level_fx[15:8];
        o.lit   = s.on_flag;
        return o;
    endfunction

    function automatic pcdf_item_t word_of(logic [1:0] k, logic on_bit, logic [7:0] tgt,
                                           logic fade_bit);
        pcdf_item_t w;
        w.kind         = k;
        w.want_on      = on_bit;
        w.target_level = tgt;
        w.fade_enable  = fade_bit;
        return w;
    endfunction

    // A word of the given kind whose other fields are random; the block
    // ignores them for anything but a command.
    function automatic pcdf_item_t rand_word(logic [1:0] k);
        return word_of(k, 1'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    // Commands lean toward "on" and toward the level extremes.
    function automatic pcdf_item_t rand_command();
        int unsigned pick;
        logic [7:0] tgt;
        pick = $urandom_range(7);
        if (pick == 0)
            tgt = 8'd0;
        else if (pick == 1)
            tgt = 8'd255;
        else
            tgt = 8'($urandom);
        return word_of(KIND_CMD, $urandom_range(3) != 0, tgt, 1'($urandom));
    endfunction

    // Queue a word and advance the planner. Returns 1 when the word changes
    // the state, so that ignored words do not count toward a phase's length.
    function automatic int put_word(pcdf_item_t w);
        lamp_state_t nxt;
        nxt = dimmer_next(plan_st, w, cfg_now);
        word_q.push_back(w);
        if (nxt != plan_st)
        begin
            plan_st = nxt;
            return 1;
        end
        return 0;
    endfunction

    // One mains half cycle: a crossing, then ticks until the firing delay has
    // run out, with the odd command or stray word mixed in.
    function automatic int half_cycle();
        int n;
        int unsigned r;
        n = put_word(rand_word(KIND_ZC));
        while (plan_st.armed)
        begin
            r = $urandom_range(99);
            if (r < 4)
                n += put_word(rand_command());
            else if (r < 7)
                n += put_word(rand_word($urandom_range(1) ? KIND_ZC : KIND_SPARE));
            else
                n += put_word(rand_word(KIND_TICK));
        end
        repeat ($urandom_range(2))
            n += put_word(rand_word(KIND_TICK));
        return n;
    endfunction

    // Fill one phase: mostly complete half cycles, some commands, some noise.
    // Without half cycles, long delays are left to run on their own.
    task automatic fill_phase(input int budget, input bit with_cycles);
        int done;
        int unsigned pick;
        done = 0;
        while (done < budget)
        begin
            pick = $urandom_range(99);
            if (with_cycles && pick < 65)
                done += half_cycle();
            else if (pick < 85)
                done += put_word(rand_command());
            else
                done += put_word(rand_word(2'($urandom)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] rate, input logic [7:0] slope,
                              input logic [15:0] offs);
        write_reg(REG_FADE_RATE, 32'(rate));
        write_reg(REG_DELAY_SLOPE, 32'(slope));
        write_reg(REG_DELAY_OFFSET, 32'(offs));
        cfg_now.fade_rate    = rate;
        cfg_now.delay_slope  = slope;
        cfg_now.delay_offset = offs;
    endtask

    // Wait until every queued word has gone in and every
    // result has come back; the block then has nothing in flight. The check
    // runs at the rising edge, where the sender's last choice has settled.
    task automatic wait_idle();
        while (word_q.size() != 0 || item_valid || lamp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // A stretch of results during which neither side idles.
    function automatic bit calm_stretch();
        return results_seen >= 150 && results_seen < 350;
    endfunction

    // Sender: offers the next queued word at a falling edge once the previous
    // one has been taken, sometimes idling instead.
    always @(negedge clk)
    begin
        pcdf_item_t w;
        if (rst_n && (!item_valid || item_taken))
        begin
            if (word_q.size() != 0 && (calm_stretch() || $urandom_range(99) >= 10))
            begin
                w = word_q.pop_front();
                item_valid   <= 1'b1;
                kind         <= w.kind;
                want_on      <= w.want_on;
                target_level <= w.target_level;
                fade_enable  <= w.fade_enable;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: idles now and then, and once holds off for a long stretch so
    // that the block fills up and has to stall its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= 300;
            hold_done    <= 1'b1;
        end
        else
        begin
            result_ready <= calm_stretch() || $urandom_range(99) >= 10;
        end
    end

    // Checker: every accepted word advances the predicted state and owes one
    // result; every accepted result is matched against the oldest one owed.
    always @(posedge clk)
    begin
        lamp_out_t want;
        lamp_out_t seen;
        item_taken <= item_valid && item_ready;
        if (item_valid && item_ready)
        begin
            live_st = dimmer_next(live_st,
                                  word_of(kind, want_on, target_level, fade_enable), cfg_now);
            lamp_q.push_back(lamp_view(live_st));
        end
        if (result_valid && result_ready)
        begin
            seen.gate  = gate_drive;
            seen.level = level_now;
            seen.lit   = lamp_on;
            if (lamp_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: gate %0b level %0d on %0b",
                             seen.gate, seen.level, seen.lit);
            end
            else
            begin
                want = lamp_q.pop_front();
                if (seen.gate !== want.gate || seen.level !== want.level
                        || seen.lit !== want.lit)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("result %0d: expected gate %0b level %0d on %0b",
                                 results_seen, want.gate, want.level, want.lit);
                        $display("result %0d: got gate %0b level %0d on %0b",
                                 results_seen, seen.gate, seen.level, seen.lit);
                    end
                end
            end
            results_seen++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_phase_cut_dimmer_with_fade_unit failed");
        $finish;
    end

    initial
    begin
        cfg_now.fade_rate    = FADE_RATE_RST;
        cfg_now.delay_slope  = DELAY_SLOPE_RST;
        cfg_now.delay_offset = DELAY_OFFSET_RST;
        plan_st = reset_state();
        live_st = reset_state();
        rst_n   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset settings. A tick with nothing armed
        // and the unused kind code change nothing. Crossings at full dark and
        // full on run the fade step at once: a jump to full, a jump to dark
        // that clears the on flag, then one fading step up from dark.
        void'(put_word(word_of(KIND_TICK, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_SPARE, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_CMD, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_ZC, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_CMD, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        wait_idle();

        // Largest fade rate with a zero-length delay: a crossing that comes in
        // while the delay is armed is dropped, the next tick fires, and the
        // level saturates at the target going up and at dark going down.
        set_config(16'hFFFF, 8'd0, 16'd0);
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_ZC, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_CMD, 1'b1, 8'd200, 1'b1)));
        void'(put_word(word_of(KIND_TICK, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_TICK, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_CMD, 1'b0, 8'd200, 1'b1)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_TICK, 1'b0, 8'd0, 1'b0)));
        wait_idle();

        // With fading off the level jumps to the target; with fading on, a fade rate of zero leaves it where it is.
        set_config(16'd0, 8'd0, 16'd0);
        void'(put_word(word_of(KIND_CMD, 1'b1, 8'd128, 1'b0)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_CMD, 1'b1, 8'd255, 1'b1)));
        void'(put_word(word_of(KIND_ZC, 1'b0, 8'd0, 1'b0)));
        void'(put_word(word_of(KIND_TICK, 1'b0, 8'd0, 1'b0)));
        wait_idle();

        // Random phases, each under its own settings. The last one uses the
        // longest delays and lets them run without waiting for them to fire.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(16'($urandom_range(1023, 1)), 8'd0, 16'($urandom_range(4)));
                1: set_config(16'd1, 8'd1, 16'd0);
                2: set_config(16'($urandom_range(4096, 256)), 8'd0, 16'd10);
                3: set_config(16'hFFFF, 8'd0, 16'd0);
                4: set_config(16'($urandom_range(65535, 1)), 8'($urandom_range(2)),
                              16'($urandom_range(30)));
                default: set_config(16'h8000, 8'd255, 16'hFFFF);
            endcase
            fill_phase(phase == 5 ? 60 : 160, phase != 5);
            // With the queue full, ask the receiver for its long hold-off.
            if (phase == 2)
                hold_req = 1'b1;
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (fault_count == 0 && lamp_q.size() == 0)
            $display("tb_phase_cut_dimmer_with_fade_unit passed");
        else
            $display("tb_phase_cut_dimmer_with_fade_unit failed");
        $finish;
    end

endmodule
